// File: hdl/bsls_pkg.sv
// Package for the bounded sequence list store.
// Holds operation and status codes, the cell control struct and the default sizes.
// No dependencies.
package bsls_pkg;

  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 6;
  localparam int DEPTH_DEF = 32;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_INS_AFTER  = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_SORTED     = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_REMOVE_VAL = 3'd5,
    OP_POP_BACK   = 3'd6,
    OP_DUMP       = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  // What every cell does with its element in this cycle.
  typedef enum logic [1:0] {
    M_HOLD   = 2'd0,
    M_INSERT = 2'd1,
    M_REMOVE = 2'd2,
    M_ROTATE = 2'd3
  } cell_mode_t;

  // Which comparison marks a cell as a hit.
  typedef enum logic [1:0] {
    H_NONE   = 2'd0,
    H_EQ_REF = 2'd1,
    H_EQ_VAL = 2'd2,
    H_SORT   = 2'd3
  } hit_sel_t;

  typedef struct packed {
    cell_mode_t               mode;
    hit_sel_t                 hit_sel;
    logic                     incl;
    logic                     force_all;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] reference;
  } cell_ctl_t;

endpackage

// File: hdl/bounded_sequence_list_store.sv
// Bounded sequence list store: an ordered list of signed values in a chain of cells.
// A dump of a non-empty list of N elements gives N results, one per cycle while the output is
// not stalled. Any other result is registered at the end of the cycle its input is taken; a dump
// passes through the state register first and holds off the input until its last result is loaded.
// A new transaction is taken when no dump is running and the output register is free.
// Synchronous reset empties the list; element contents stay undefined until written.
module bounded_sequence_list_store import bsls_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // op[2:0], value[34:3], reference[66:35], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status[1:0], data[33:2], count[39:34]
  output logic        m_tlast
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t                   state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [CNT_W-1:0]         dump_idx, dump_idx_next;
  logic [STATUS_W-1:0]      out_status, out_status_next;
  logic signed [DATA_W-1:0] out_data, out_data_next;
  logic [COUNT_W-1:0]       out_count, out_count_next;
  logic                     out_last, out_last_next;
  logic                     out_load;

  op_t                      op;
  logic                     accept, step, full, empty, found, dump_end;
  cell_ctl_t                ctl;

  logic [DEPTH-1:0]              occ, tail, t_vec, f_vec;
  logic signed [DATA_W-1:0]      e_vec [DEPTH];

  assign op     = op_t'(s_tdata[2:0]);
  assign full   = (count >= CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign accept = s_tvalid && s_tready;
  assign found  = f_vec[DEPTH-1];
  assign step   = (state == S_DUMP) && (!m_tvalid || m_tready);
  assign dump_end = (CNT_W'(dump_idx + 1'b1) == count);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i]  = (CNT_W'(i) < count);
    assign tail[i] = (CNT_W'(i + 1) == count);
    bsls_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .occ     (occ[i]),
      .tail    (tail[i]),
      .first   (i == 0),
      .t_left  ((i == 0) ? 1'b0 : t_vec[(i == 0) ? 0 : i-1]),
      .f_in    ((i == 0) ? 1'b0 : f_vec[(i == 0) ? 0 : i-1]),
      .e_left  ((i == 0) ? '0 : e_vec[(i == 0) ? 0 : i-1]),
      .e_right ((i == DEPTH-1) ? '0 : e_vec[(i == DEPTH-1) ? i : i+1]),
      .e_head  (e_vec[0]),
      .e       (e_vec[i]),
      .t       (t_vec[i]),
      .f_out   (f_vec[i])
    );
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && op == OP_DUMP && !empty) state_next = S_DUMP;
      S_DUMP: if (step && dump_end) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the controller: handshake, cell control and the next result.
  always_comb begin
    s_tready        = (state == S_IDLE) && (!m_tvalid || m_tready);
    ctl.mode        = M_HOLD;
    ctl.hit_sel     = H_NONE;
    ctl.incl        = 1'b0;
    ctl.force_all   = 1'b0;
    ctl.value       = $signed(s_tdata[34:3]);
    ctl.reference   = $signed(s_tdata[66:35]);
    count_next      = count;
    dump_idx_next   = dump_idx;
    out_load        = 1'b0;
    out_status_next = ST_OK;
    out_data_next   = '0;
    out_last_next   = 1'b1;

    unique case (op)
      OP_PUSH_FRONT: ctl.force_all = 1'b1;
      OP_INS_AFTER:  ctl.hit_sel   = H_EQ_REF;
      OP_PUSH_BACK:  ctl.hit_sel   = H_NONE;
      OP_SORTED: begin
        ctl.hit_sel = H_SORT;
        ctl.incl    = 1'b1;
      end
      OP_POP_FRONT:  ctl.force_all = 1'b1;
      OP_REMOVE_VAL: begin
        ctl.hit_sel = H_EQ_VAL;
        ctl.incl    = 1'b1;
      end
      OP_POP_BACK:   ctl.hit_sel   = H_NONE;
      OP_DUMP:       ctl.hit_sel   = H_NONE;
      default:       ctl.hit_sel   = H_NONE;
    endcase

    if (accept) begin
      unique case (op)
        OP_PUSH_FRONT, OP_INS_AFTER, OP_PUSH_BACK, OP_SORTED: begin
          if (full) begin
            out_status_next = ST_FULL;
          end else begin
            ctl.mode   = M_INSERT;
            count_next = count + 1'b1;
          end
          out_load = 1'b1;
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (empty) begin
            out_status_next = ST_EMPTY;
          end else begin
            ctl.mode   = (op == OP_POP_FRONT) ? M_REMOVE : M_HOLD;
            count_next = count - 1'b1;
          end
          out_load = 1'b1;
        end
        OP_REMOVE_VAL: begin
          if (empty) begin
            out_status_next = ST_EMPTY;
          end else if (!found) begin
            out_status_next = ST_MISSING;
          end else begin
            ctl.mode   = M_REMOVE;
            count_next = count - 1'b1;
          end
          out_load = 1'b1;
        end
        OP_DUMP: begin
          dump_idx_next = '0;
          if (empty) begin
            out_status_next = ST_EMPTY;
            out_load        = 1'b1;
          end
        end
        default: out_load = 1'b0;
      endcase
    end else if (step) begin
      // The list rotates by one so that cell zero always holds the next element.
      ctl.mode      = M_ROTATE;
      out_load      = 1'b1;
      out_data_next = e_vec[0];
      out_last_next = dump_end;
      dump_idx_next = CNT_W'(dump_idx + 1'b1);
    end

    out_count_next = COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      dump_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_idx <= dump_idx_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= out_status_next;
      out_data   <= out_data_next;
      out_count  <= out_count_next;
      out_last   <= out_last_next;
    end
  end

  assign m_tdata = {out_count, out_data, out_status};
  assign m_tlast = out_last;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count above capacity");

  // A dump only runs over a non-empty list.
  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> (count != '0))
    else $error("dump running on empty list");

  // The list length does not change while a dump rotates it.
  a_dump_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |=> (count == $past(count)))
    else $error("count changed during dump");

  // No input transaction is taken during a dump.
  a_no_accept_dump: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> !s_tready)
    else $error("input taken during dump");

endmodule

// File: hdl/bsls_cell.sv
// One cell of the list chain: holds one element and decides its next value
// from its neighbors and the shared control struct. Depends on bsls_pkg.
module bsls_cell import bsls_pkg::*; (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic                     occ,
  input  logic                     tail,
  input  logic                     first,
  input  logic                     t_left,
  input  logic                     f_in,
  input  logic signed [DATA_W-1:0] e_left,
  input  logic signed [DATA_W-1:0] e_right,
  input  logic signed [DATA_W-1:0] e_head,
  output logic signed [DATA_W-1:0] e,
  output logic                     t,
  output logic                     f_out
);

  logic                     hit;
  logic signed [DATA_W-1:0] e_next;

  // The head of a sorted insert goes in front only on a strict compare.
  always_comb begin
    case (ctl.hit_sel)
      H_EQ_REF: hit = occ && (e == ctl.reference);
      H_EQ_VAL: hit = occ && (e == ctl.value);
      H_SORT:   hit = occ && (first ? (ctl.value < e) : (ctl.value <= e));
      default:  hit = 1'b0;
    endcase
  end

  // t is the position thermometer: high when the edit point is at or before this cell.
  assign f_out = f_in | hit;
  assign t     = ctl.force_all | !occ | f_in | (ctl.incl & hit);

  always_comb begin
    case (ctl.mode)
      M_INSERT: e_next = t_left ? e_left : (t ? ctl.value : e);
      M_REMOVE: e_next = t ? e_right : e;
      M_ROTATE: e_next = tail ? e_head : e_right;
      default:  e_next = e;
    endcase
  end

  always_ff @(posedge clk) begin
    e <= e_next;
  end

endmodule
